// ===== hw/rtl/stm_pkg.sv =====
// ----------------------------------------------------------------------------
// stm_pkg: shared constants, types and sine table for the sine tone mixer
// Holds field widths, register index codes, the controller/datapath command
// bundle and the quarter-wave sine table built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package stm_pkg;

  localparam int CHANNELS         = 16;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int PHASE_BITS       = 32;

  localparam int TABLE_BITS    = $clog2(SINE_TABLE_DEPTH);
  localparam int QUARTER_DEPTH = SINE_TABLE_DEPTH / 4;
  localparam int QIDX_W        = TABLE_BITS - 1;  // holds 0 .. QUARTER_DEPTH

  localparam int SAMPLE_W   = 24;
  localparam int AMP_W      = 23;
  localparam int STEP_W     = 32;
  localparam int FPB_W      = 13;
  localparam int FIDX_W     = 12;
  localparam int CH_W       = 4;
  localparam int MASK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int KMAX        = 4096;
  localparam int FIDX_MAX    = 4095;
  localparam int FPB_RESET   = 64;
  localparam int PROD_W      = AMP_W + FPB_W;   // |diff| * k
  localparam int TONE_PROD_W = 2 * AMP_W;       // amp * |sine|
  localparam int DIV_CNT_W   = $clog2(AMP_W + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_AMPLITUDE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_BLOCK = 3'd4;

  typedef longint unsigned u64_t;
  typedef longint          s64_t;

  typedef logic [AMP_W-1:0] qsine_t;
  typedef qsine_t qsine_table_t [QUARTER_DEPTH+1];

  typedef struct packed {
    logic accept;     // item taken this cycle
    logic frame;      // item taken and it opens a frame
    logic mul1;       // ramp product, table read, frame index step
    logic div_start;  // load divider
    logic amp;        // form ramp amplitude
    logic mul2;       // amplitude times sine
    logic tone;       // round, sign, store tone
    logic out_load;   // mix and load output register
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  localparam u64_t HALF_PI_Q30 = 64'd1686629713;
  localparam u64_t FULL_SCALE  = 64'd8388607;
  localparam int unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  // sin(pi/2 * r / QUARTER_DEPTH) in Q0.23, Q30 Taylor series through x^15
  function automatic qsine_t quarter_sine(input int unsigned r);
    u64_t x;
    u64_t t;
    s64_t sum;
    u64_t v;
    x   = (HALF_PI_Q30 * u64_t'(r)) / QUARTER_DEPTH;
    t   = x;
    sum = s64_t'(x);
    for (int n = 0; n < 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / TAYLOR_DIV[n];
      if ((n % 2) == 0) begin
        sum = sum - s64_t'(t);
      end else begin
        sum = sum + s64_t'(t);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = ((u64_t'(sum) * FULL_SCALE) + (u64_t'(1) << 29)) >> 30;
    if (v > FULL_SCALE) begin
      v = FULL_SCALE;
    end
    return v[AMP_W-1:0];
  endfunction

  function automatic qsine_table_t build_qsine();
    qsine_table_t tbl;
    for (int i = 0; i <= QUARTER_DEPTH; i++) begin
      tbl[i] = quarter_sine(i);
    end
    return tbl;
  endfunction

  localparam qsine_table_t QSINE_TABLE = build_qsine();

endpackage

`default_nettype wire

// ===== hw/rtl/stm_div.sv =====
// ----------------------------------------------------------------------------
// stm_div: iterative restoring divider for the amplitude ramp
// One quotient bit per cycle. The quotient is known to fit AMP_W bits, so
// the top dividend bits seed the remainder and AMP_W steps finish the job.
// ----------------------------------------------------------------------------
`default_nettype none

module stm_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [stm_pkg::PROD_W-1:0] dividend,
  input  wire logic [stm_pkg::FPB_W-1:0]  divisor,
  output logic      [stm_pkg::AMP_W-1:0]  quotient,
  output logic                           done
);
  import stm_pkg::*;

  logic [FPB_W-1:0]     rem_r, rem_nxt;
  logic [AMP_W-1:0]     shreg_r, shreg_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FPB_W:0]       rem2;
  logic [FPB_W:0]       rem_sub;
  logic                 ge;

  assign rem2    = {rem_r, shreg_r[AMP_W-1]};
  assign rem_sub = rem2 - {1'b0, divisor};
  assign ge      = (rem2 >= {1'b0, divisor});

  always_comb begin
    rem_nxt   = rem_r;
    shreg_nxt = shreg_r;
    cnt_nxt   = cnt_r;
    if (start) begin
      rem_nxt   = dividend[PROD_W-1:AMP_W];
      shreg_nxt = dividend[AMP_W-1:0];
      cnt_nxt   = DIV_CNT_W'(AMP_W);
    end else if (cnt_r != '0) begin
      rem_nxt   = ge ? rem_sub[FPB_W-1:0] : rem2[FPB_W-1:0];
      shreg_nxt = {shreg_r[AMP_W-2:0], ge};
      cnt_nxt   = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    shreg_r <= shreg_nxt;
  end

  assign quotient = shreg_r;
  assign done     = (cnt_r == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/stm_datapath.sv =====
// ----------------------------------------------------------------------------
// stm_datapath: registers and arithmetic of the sine tone mixer
// Config registers, phase accumulator, ramp state, sine lookup, multipliers,
// mixing with saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stm_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire stm_pkg::cmd_t                     cmd,
  output stm_pkg::status_t                       status,
  input  wire logic                              cfg_write_en,
  input  wire logic        [stm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [stm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic signed [stm_pkg::SAMPLE_W-1:0]   in_sample_in,
  input  wire logic        [stm_pkg::CH_W-1:0]       in_channel,
  input  wire logic                              in_block_start,
  output logic signed      [stm_pkg::SAMPLE_W-1:0]   out_sample_out,
  output logic             [stm_pkg::CH_W-1:0]       out_channel_out,
  output logic                                   out_clipped
);
  import stm_pkg::*;

  // config
  logic [STEP_W-1:0] phase_step_r;
  logic [AMP_W-1:0]  tone_amplitude_r;
  logic              mix_mode_r;
  logic [MASK_W-1:0] channel_mask_r;
  logic [FPB_W-1:0]  frames_per_block_r;

  // oscillator / ramp state
  logic [PHASE_BITS-1:0]      phase_r;
  logic [AMP_W-1:0]           start_amp_r;
  logic [AMP_W-1:0]           target_amp_r;
  logic [FIDX_W-1:0]          fidx_r;
  logic signed [SAMPLE_W-1:0] tone_r;

  // working registers
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [CH_W-1:0]            ch_r;
  logic [PROD_W-1:0]          rprod_r;
  logic                       diff_neg_r;
  qsine_t                     sine_r;
  logic                       sine_neg_r;
  logic [AMP_W-1:0]           amp_r;
  logic [TONE_PROD_W-1:0]     tprod_r;

  // phase step aligned to PHASE_BITS
  logic [PHASE_BITS+STEP_W-1:0] step_wide;
  logic [PHASE_BITS-1:0]        step_al;
  assign step_wide = {phase_step_r, {PHASE_BITS{1'b0}}};
  assign step_al   = step_wide[PHASE_BITS+STEP_W-1:STEP_W];

  // ramp length clamp and ramp position
  logic [FPB_W-1:0]  n_len;
  logic [FPB_W-1:0]  k_pos;
  logic signed [AMP_W:0] diff;
  logic [AMP_W-1:0]  diff_mag;

  always_comb begin
    if (frames_per_block_r == '0) begin
      n_len = FPB_W'(1);
    end else if (frames_per_block_r > FPB_W'(KMAX)) begin
      n_len = FPB_W'(KMAX);
    end else begin
      n_len = frames_per_block_r;
    end
    k_pos = ({1'b0, fidx_r} > n_len) ? n_len : {1'b0, fidx_r};
  end

  assign diff     = signed'({1'b0, target_amp_r}) - signed'({1'b0, start_amp_r});
  assign diff_mag = diff[AMP_W] ? AMP_W'(-diff) : diff[AMP_W-1:0];

  // sine lookup address, quarter-wave symmetry
  logic [TABLE_BITS-1:0] tidx;
  logic [1:0]            quad;
  logic [QIDX_W-1:0]     r_ext;
  logic [QIDX_W-1:0]     qaddr;
  assign tidx  = phase_r[PHASE_BITS-1 -: TABLE_BITS];
  assign quad  = tidx[TABLE_BITS-1 -: 2];
  assign r_ext = {1'b0, tidx[TABLE_BITS-3:0]};
  assign qaddr = quad[0] ? (QIDX_W'(QUARTER_DEPTH) - r_ext) : r_ext;

  // divider
  logic [AMP_W-1:0] quot;
  logic             div_done;

  stm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rprod_r),
    .divisor  (n_len),
    .quotient (quot),
    .done     (div_done)
  );

  assign status.div_done = div_done;

  // tone rounding
  logic [TONE_PROD_W:0] tround;
  logic [AMP_W-1:0]     tmag;
  assign tround = {1'b0, tprod_r} + (TONE_PROD_W+1)'(1 << (AMP_W - 1));
  assign tmag   = tround[TONE_PROD_W-1:AMP_W];

  // mixing
  logic                       sel;
  logic signed [SAMPLE_W:0]   mix_sum;
  logic                       mix_ovf;
  logic signed [SAMPLE_W-1:0] mix_sat;
  logic signed [SAMPLE_W-1:0] mix_val;
  logic                       mix_clip;

  assign sel     = (32'(ch_r) < CHANNELS) && channel_mask_r[ch_r];
  assign mix_sum = {sample_r[SAMPLE_W-1], sample_r} + {tone_r[SAMPLE_W-1], tone_r};
  assign mix_ovf = (mix_sum[SAMPLE_W] != mix_sum[SAMPLE_W-1]);
  assign mix_sat = mix_sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                     : {1'b0, {(SAMPLE_W-1){1'b1}}};

  always_comb begin
    mix_val  = sample_r;
    mix_clip = 1'b0;
    if (sel) begin
      if (mix_mode_r) begin
        mix_val  = mix_ovf ? mix_sat : mix_sum[SAMPLE_W-1:0];
        mix_clip = mix_ovf;
      end else begin
        mix_val = tone_r;
      end
    end
  end

  // config and oscillator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r       <= '0;
      tone_amplitude_r   <= '0;
      mix_mode_r         <= 1'b0;
      channel_mask_r     <= '0;
      frames_per_block_r <= FPB_W'(FPB_RESET);
      phase_r            <= '0;
      start_amp_r        <= '0;
      target_amp_r       <= '0;
      fidx_r             <= '0;
      tone_r             <= '0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_PHASE_STEP:       phase_step_r       <= cfg_data[STEP_W-1:0];
          REG_TONE_AMPLITUDE:   tone_amplitude_r   <= cfg_data[AMP_W-1:0];
          REG_MIX_MODE:         mix_mode_r         <= cfg_data[0];
          REG_CHANNEL_MASK:     channel_mask_r     <= cfg_data[MASK_W-1:0];
          REG_FRAMES_PER_BLOCK: frames_per_block_r <= cfg_data[FPB_W-1:0];
          default: ;
        endcase
      end
      if (cmd.frame) begin
        phase_r <= (phase_step_r == '0) ? '0 : phase_r + step_al;
        if (in_block_start) begin
          start_amp_r  <= target_amp_r;
          target_amp_r <= tone_amplitude_r;
          fidx_r       <= '0;
        end
      end
      if (cmd.mul1 && (fidx_r != FIDX_W'(FIDX_MAX))) begin
        fidx_r <= fidx_r + 1'b1;
      end
      if (cmd.tone) begin
        tone_r <= sine_neg_r ? -signed'({1'b0, tmag}) : signed'({1'b0, tmag});
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample_in;
      ch_r     <= in_channel;
    end
    if (cmd.mul1) begin
      rprod_r    <= PROD_W'(diff_mag * k_pos);
      diff_neg_r <= diff[AMP_W];
      sine_r     <= QSINE_TABLE[qaddr];
      sine_neg_r <= quad[1];
    end
    if (cmd.amp) begin
      amp_r <= diff_neg_r ? (start_amp_r - quot) : (start_amp_r + quot);
    end
    if (cmd.mul2) begin
      tprod_r <= TONE_PROD_W'(amp_r * sine_r);
    end
    if (cmd.out_load) begin
      out_sample_out  <= mix_val;
      out_channel_out <= ch_r;
      out_clipped     <= mix_clip;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stm_ctrl.sv =====
// ----------------------------------------------------------------------------
// stm_ctrl: sequencer of the sine tone mixer
// Takes one item at a time, walks the datapath through the frame steps and
// owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module stm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_frame_start,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output stm_pkg::cmd_t          cmd,
  input  wire stm_pkg::status_t  status
);
  import stm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL1  = 3'd1;
  localparam logic [2:0] S_DIVLD = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_AMP   = 3'd4;
  localparam logic [2:0] S_MUL2  = 3'd5;
  localparam logic [2:0] S_TONE  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.accept    = accept;
    cmd.frame     = accept && in_frame_start;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = in_frame_start ? S_MUL1 : S_OUT;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_DIVLD;
      end
      S_DIVLD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_nxt = S_AMP;
        end
      end
      S_AMP: begin
        cmd.amp   = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_TONE;
      end
      S_TONE: begin
        cmd.tone  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sine_tone_mixer.sv =====
// ----------------------------------------------------------------------------
// sine_tone_mixer: sine oscillator mixed into a multichannel sample stream
// Items with frame start run the ramp divider before the output step.
// One item in flight: the next item is taken once the last one has been
// loaded into the output register. Sync reset clears config, phase, ramp
// state, tone and valid; ramp length goes back to 64.
// ----------------------------------------------------------------------------
`default_nettype none

// Structure
//   stm_ctrl     : sequencer, input stall, output valid
//   stm_datapath : config regs, phase accumulator, ramp, sine lookup, mixer
//     stm_div    : one-bit-per-cycle divider for the ramp quotient
//
// Frame item flow (after acceptance, phase and block state already updated):
//   MUL1  |diff| * k, quarter-wave table read, frame index step
//   DIVLD seed divider with |diff| * k
//   DIV   23 quotient steps, divide by the clamped ramp length
//   AMP   start +/- quotient
//   MUL2  amp * |sine|
//   TONE  round half up, restore sign, store tone
//   OUT   mix into the sample, saturate in add mode, load output register
// Items without frame start go straight to OUT and reuse the stored tone.
//
// The output register decouples the two sides: a new item is accepted while
// a finished one still waits on out_stall. Only the OUT step waits on it.
// Config writes are expected only while the block is idle.

module sine_tone_mixer (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input items
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [stm_pkg::SAMPLE_W-1:0]   in_sample_in,
  input  wire logic        [stm_pkg::CH_W-1:0]       in_channel,
  input  wire logic                                  in_frame_start,
  input  wire logic                                  in_block_start,
  // result items
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed      [stm_pkg::SAMPLE_W-1:0]   out_sample_out,
  output logic             [stm_pkg::CH_W-1:0]       out_channel_out,
  output logic                                       out_clipped,
  // configuration writes
  input  wire logic                                  cfg_write_en,
  input  wire logic        [stm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [stm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import stm_pkg::*;

  cmd_t    cmd;
  status_t status;

  stm_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_frame_start (in_frame_start),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .status         (status)
  );

  stm_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_sample_in    (in_sample_in),
    .in_channel      (in_channel),
    .in_block_start  (in_block_start),
    .out_sample_out  (out_sample_out),
    .out_channel_out (out_channel_out),
    .out_clipped     (out_clipped)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/stm_checker.sv =====
// ----------------------------------------------------------------------------
// stm_checker: port-level checks for the sine tone mixer
// Watches handshakes and result items on the top level ports; bound below.
// ----------------------------------------------------------------------------
`default_nettype none

module stm_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic signed [stm_pkg::SAMPLE_W-1:0] out_sample_out,
  input wire logic                                out_clipped
);
  import stm_pkg::*;

  // held result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // held result keeps its sample
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_sample_out))
    else $error("result sample changed while stalled");

  // one item at a time: input stalls right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

  // a clipped item sits at full scale
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      (out_sample_out == 24'sh7FFFFF) || (out_sample_out == -24'sh800000))
    else $error("clip flagged off the rails");

  // no result straight out of reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sine_tone_mixer stm_checker u_stm_checker (.*);

`default_nettype wire
